// File: hw/rtl/gshbtb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gshbtb_pkg
// Shared constants and types for the gshare predictor with a target buffer.
// ----------------------------------------------------------------------------
package gshbtb_pkg;

  localparam int TABLE_ENTRIES  = 16;
  localparam int HISTORY_BITS   = 4;
  localparam int BUFFER_ENTRIES = 4;
  localparam int ADDR_BITS      = 16;
  localparam int INDEX_BITS     = $clog2(TABLE_ENTRIES);
  localparam int CTR_BITS       = 2;
  localparam int TOTAL_BITS     = 32;

  localparam logic [CTR_BITS-1:0]     CTR_RESET  = 2'd1;
  localparam logic [CTR_BITS-1:0]     CTR_MAX    = 2'd3;
  localparam logic [CTR_BITS-1:0]     CTR_MIN    = 2'd0;
  localparam logic [HISTORY_BITS-1:0] HIST_RESET = '1;

  typedef enum logic {
    KIND_PREDICT = 1'b0,
    KIND_RESOLVE = 1'b1
  } kind_t;

  typedef struct packed {
    logic                 vld;
    logic [ADDR_BITS-1:0] tag;
    logic [ADDR_BITS-1:0] target;
  } btb_entry_t;

  typedef struct packed {
    logic                 shift;
    logic [ADDR_BITS-1:0] lookup_pc;
  } btb_ctrl_t;

  typedef struct packed {
    logic                  update;
    logic                  taken;
    logic [INDEX_BITS-1:0] pc_bits;
  } pht_req_t;

endpackage : gshbtb_pkg
`default_nettype wire

// File: hw/rtl/gshbtb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gshbtb_cell
// One target buffer entry; on an insert it takes its neighbor's entry.
// ----------------------------------------------------------------------------
module gshbtb_cell (
  input  wire                    clk,
  input  wire                    rst_n,
  input  gshbtb_pkg::btb_ctrl_t  ctrl,
  input  gshbtb_pkg::btb_entry_t prev,
  output gshbtb_pkg::btb_entry_t entry,
  output logic                   match
);

  logic                             vld_r;
  logic [gshbtb_pkg::ADDR_BITS-1:0] tag_r;
  logic [gshbtb_pkg::ADDR_BITS-1:0] target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctrl.shift) begin
      vld_r <= prev.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      tag_r    <= prev.tag;
      target_r <= prev.target;
    end
  end

  assign entry.vld    = vld_r;
  assign entry.tag    = tag_r;
  assign entry.target = target_r;
  assign match        = vld_r && (tag_r == ctrl.lookup_pc);

endmodule : gshbtb_cell
`default_nettype wire

// File: hw/rtl/gshbtb_pht.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gshbtb_pht
// Pattern history table of saturating counters and the global history.
// ----------------------------------------------------------------------------
module gshbtb_pht (
  input  wire                                clk,
  input  wire                                rst_n,
  input  gshbtb_pkg::pht_req_t               req,
  output logic [gshbtb_pkg::CTR_BITS-1:0]    rd_ctr
);

  logic [gshbtb_pkg::CTR_BITS-1:0]     tbl_r [gshbtb_pkg::TABLE_ENTRIES];
  logic [gshbtb_pkg::HISTORY_BITS-1:0] hist_r;
  logic [gshbtb_pkg::HISTORY_BITS-1:0] hist_nxt;
  logic                                hist_vld_r;
  logic [gshbtb_pkg::INDEX_BITS-1:0]   idx;
  logic [gshbtb_pkg::CTR_BITS-1:0]     cur_ctr;
  logic [gshbtb_pkg::CTR_BITS-1:0]     ctr_nxt;

  assign idx     = req.pc_bits ^ hist_r[gshbtb_pkg::INDEX_BITS-1:0];
  assign cur_ctr = tbl_r[idx];
  assign rd_ctr  = hist_vld_r ? cur_ctr : gshbtb_pkg::CTR_RESET;

  always_comb begin
    ctr_nxt = cur_ctr;
    if (req.taken) begin
      if (cur_ctr != gshbtb_pkg::CTR_MAX) begin
        ctr_nxt = cur_ctr + 1'b1;
      end
    end else begin
      if (cur_ctr != gshbtb_pkg::CTR_MIN) begin
        ctr_nxt = cur_ctr - 1'b1;
      end
    end
  end

  always_comb begin
    if (hist_vld_r) begin
      hist_nxt = {hist_r[gshbtb_pkg::HISTORY_BITS-2:0], req.taken};
    end else begin
      hist_nxt = {{(gshbtb_pkg::HISTORY_BITS-1){1'b0}}, req.taken};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < gshbtb_pkg::TABLE_ENTRIES; k++) begin
        tbl_r[k] <= gshbtb_pkg::CTR_RESET;
      end
      hist_r     <= gshbtb_pkg::HIST_RESET;
      hist_vld_r <= 1'b0;
    end else if (req.update) begin
      tbl_r[idx] <= ctr_nxt;
      hist_r     <= hist_nxt;
      hist_vld_r <= 1'b1;
    end
  end

endmodule : gshbtb_pht
`default_nettype wire

// File: hw/rtl/gshare_predictor_with_btb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb
// Gshare direction predictor with a small first-in first-out target buffer.
// ----------------------------------------------------------------------------
// A transfer on start is answered by one result on the out_ ports, strobed by
// out_valid, in the following cycle, and busy is never raised, so a new item
// may be started in every cycle. This rate is set by the counter table, read
// combinationally and updated in place on the accepting clock edge, and
// by the target buffer, a row of entry cells that are all compared at once
// and that shift one place toward the oldest end on every insert. The receiver
// cannot stall; each result must be taken in the cycle in which it is shown.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  output logic                                busy,
  input  wire                                 in_kind,
  input  wire  [gshbtb_pkg::ADDR_BITS-1:0]    in_branch_pc,
  input  wire                                 in_taken,
  input  wire  [gshbtb_pkg::CTR_BITS-1:0]     in_predicted_counter,
  input  wire  [gshbtb_pkg::ADDR_BITS-1:0]    in_branch_target,
  output logic                                out_valid,
  output logic [gshbtb_pkg::CTR_BITS-1:0]     out_counter_value,
  output logic                                out_predict_taken,
  output logic                                out_btb_hit,
  output logic [gshbtb_pkg::ADDR_BITS-1:0]    out_btb_target,
  output logic                                out_mispredicted,
  output logic [gshbtb_pkg::TOTAL_BITS-1:0]   out_mispredict_total
);

  localparam int N = gshbtb_pkg::BUFFER_ENTRIES;

  logic                              accept;
  logic                              is_resolve;
  logic                              miss;
  logic                              hit;
  logic [gshbtb_pkg::ADDR_BITS-1:0]  hit_target;
  logic [gshbtb_pkg::CTR_BITS-1:0]   rd_ctr;
  logic [N-1:0]                      match;
  gshbtb_pkg::btb_entry_t            chain [N+1];
  gshbtb_pkg::btb_ctrl_t             btb_ctrl;
  gshbtb_pkg::pht_req_t              pht_req;

  logic                              valid_r;
  logic [gshbtb_pkg::TOTAL_BITS-1:0] total_r;
  logic [gshbtb_pkg::TOTAL_BITS-1:0] total_nxt;
  logic [gshbtb_pkg::CTR_BITS-1:0]   ctr_r;
  logic                              ptaken_r;
  logic                              hit_r;
  logic [gshbtb_pkg::ADDR_BITS-1:0]  target_r;
  logic                              miss_r;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign is_resolve = (in_kind == gshbtb_pkg::KIND_RESOLVE);
  assign miss       = in_taken ? !in_predicted_counter[1] : in_predicted_counter[1];

  assign pht_req.update  = accept && is_resolve;
  assign pht_req.taken   = in_taken;
  assign pht_req.pc_bits = in_branch_pc[gshbtb_pkg::INDEX_BITS-1:0];

  gshbtb_pht u_pht (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (pht_req),
    .rd_ctr (rd_ctr)
  );

  assign btb_ctrl.lookup_pc = in_branch_pc;
  assign btb_ctrl.shift     = accept && is_resolve && in_taken && !hit;

  assign chain[0].vld    = 1'b1;
  assign chain[0].tag    = in_branch_pc;
  assign chain[0].target = in_branch_target;

  for (genvar g = 0; g < N; g++) begin : g_cell
    gshbtb_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (btb_ctrl),
      .prev  (chain[g]),
      .entry (chain[g+1]),
      .match (match[g])
    );
  end

  assign hit = |match;

  always_comb begin
    hit_target = '0;
    for (int k = 0; k < N; k++) begin
      hit_target = hit_target | (match[k] ? chain[k+1].target : '0);
    end
  end

  assign total_nxt = (is_resolve && miss) ? total_r + 1'b1 : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      total_r <= '0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctr_r    <= is_resolve ? '0 : rd_ctr;
      ptaken_r <= !is_resolve && rd_ctr[1];
      hit_r    <= !is_resolve && hit;
      target_r <= is_resolve ? '0 : hit_target;
      miss_r   <= is_resolve && miss;
    end
  end

  assign out_valid            = valid_r;
  assign out_counter_value    = ctr_r;
  assign out_predict_taken    = ptaken_r;
  assign out_btb_hit          = hit_r;
  assign out_btb_target       = target_r;
  assign out_mispredicted     = miss_r;
  assign out_mispredict_total = total_r;

endmodule : gshare_predictor_with_btb
`default_nettype wire

// File: dv/gshare_predictor_with_btb_checker.sv
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb_checker
// Watches both channels of the branch predictor and checks every result.
// ----------------------------------------------------------------------------
// Each input transfer is run through a local copy of the counter table, the
// global history, the FIFO target buffer and the misprediction counter. The
// expected result is queued and compared field by field with the next result
// strobed by the block. The failure count and the number of results still
// owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb_checker (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire                                 busy,
  input  wire                                 in_kind,
  input  wire  [gshbtb_pkg::ADDR_BITS-1:0]    in_branch_pc,
  input  wire                                 in_taken,
  input  wire  [gshbtb_pkg::CTR_BITS-1:0]     in_predicted_counter,
  input  wire  [gshbtb_pkg::ADDR_BITS-1:0]    in_branch_target,
  input  wire                                 out_valid,
  input  wire  [gshbtb_pkg::CTR_BITS-1:0]     out_counter_value,
  input  wire                                 out_predict_taken,
  input  wire                                 out_btb_hit,
  input  wire  [gshbtb_pkg::ADDR_BITS-1:0]    out_btb_target,
  input  wire                                 out_mispredicted,
  input  wire  [gshbtb_pkg::TOTAL_BITS-1:0]   out_mispredict_total,
  output int                                  fail_count,
  output int                                  pending_count
);
  import gshbtb_pkg::*;

  typedef struct packed {
    logic [CTR_BITS-1:0]   counter_value;
    logic                  predict_taken;
    logic                  btb_hit;
    logic [ADDR_BITS-1:0]  btb_target;
    logic                  mispredicted;
    logic [TOTAL_BITS-1:0] mispredict_total;
  } branch_result_t;

  logic [CTR_BITS-1:0]     pht [TABLE_ENTRIES];
  logic [HISTORY_BITS-1:0] ghist;
  logic                    ghist_valid;
  logic [ADDR_BITS-1:0]    btb_tags [BUFFER_ENTRIES];
  logic [ADDR_BITS-1:0]    btb_targets [BUFFER_ENTRIES];
  int                      btb_fill;
  int                      btb_oldest;
  logic [TOTAL_BITS-1:0]   miss_total;
  int                      errors;
  branch_result_t          expected_results [$];

  initial begin
    errors = 0;
  end

  function automatic int btb_lookup(input logic [ADDR_BITS-1:0] pc);
    int slot;
    for (int k = 0; k < btb_fill; k++) begin
      slot = (btb_oldest + k) % BUFFER_ENTRIES;
      if (btb_tags[slot] == pc) return slot;
    end
    return -1;
  endfunction

  task automatic clear_branch_state();
    for (int k = 0; k < TABLE_ENTRIES; k++) pht[k] = CTR_RESET;
    for (int k = 0; k < BUFFER_ENTRIES; k++) begin
      btb_tags[k]    = '0;
      btb_targets[k] = '0;
    end
    ghist       = HIST_RESET;
    ghist_valid = 1'b0;
    btb_fill    = 0;
    btb_oldest  = 0;
    miss_total  = '0;
  endtask

  task automatic predict_and_train(input kind_t kind, input logic [ADDR_BITS-1:0] pc,
                                   input logic tk, input logic [CTR_BITS-1:0] pred,
                                   input logic [ADDR_BITS-1:0] tgt,
                                   output branch_result_t res);
    logic [INDEX_BITS-1:0] idx;
    logic                  miss;
    int                    slot;
    int                    wr_slot;
    res  = '0;
    slot = btb_lookup(pc);
    idx  = pc[INDEX_BITS-1:0] ^ ghist;
    if (kind == KIND_PREDICT) begin
      res.counter_value = ghist_valid ? pht[idx] : CTR_RESET;
      res.predict_taken = res.counter_value >= 2;
      if (slot >= 0) begin
        res.btb_hit    = 1'b1;
        res.btb_target = btb_targets[slot];
      end
    end else begin
      if (tk) begin
        if (pht[idx] != CTR_MAX) pht[idx] = pht[idx] + 1'b1;
        miss = (pred <= 1);
      end else begin
        if (pht[idx] != CTR_MIN) pht[idx] = pht[idx] - 1'b1;
        miss = (pred >= 2);
      end
      if (miss) miss_total = miss_total + 1'b1;
      // An empty history is replaced by the first outcome alone.
      ghist       = ghist_valid ? {ghist[HISTORY_BITS-2:0], tk} : {{(HISTORY_BITS-1){1'b0}}, tk};
      ghist_valid = 1'b1;
      if (tk && slot < 0) begin
        if (btb_fill < BUFFER_ENTRIES) begin
          wr_slot  = (btb_oldest + btb_fill) % BUFFER_ENTRIES;
          btb_fill = btb_fill + 1;
        end else begin
          wr_slot    = btb_oldest;
          btb_oldest = (btb_oldest + 1) % BUFFER_ENTRIES;
        end
        btb_tags[wr_slot]    = pc;
        btb_targets[wr_slot] = tgt;
      end
      res.mispredicted = miss;
    end
    res.mispredict_total = miss_total;
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    branch_result_t exp_r;
    branch_result_t new_r;
    if (!rst_n) begin
      clear_branch_state();
      expected_results.delete();
    end else begin
      // The result strobed now belongs to a transfer of an earlier edge.
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result strobed with no transfer outstanding");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("counter_value", exp_r.counter_value, out_counter_value);
          check_field("predict_taken", exp_r.predict_taken, out_predict_taken);
          check_field("btb_hit", exp_r.btb_hit, out_btb_hit);
          check_field("btb_target", exp_r.btb_target, out_btb_target);
          check_field("mispredicted", exp_r.mispredicted, out_mispredicted);
          check_field("mispredict_total", exp_r.mispredict_total, out_mispredict_total);
        end
      end
      if (start && !busy) begin
        predict_and_train(kind_t'(in_kind), in_branch_pc, in_taken, in_predicted_counter,
                          in_branch_target, new_r);
        expected_results.insert(expected_results.size(), new_r);
      end
    end
    fail_count    <= errors;
    pending_count <= expected_results.size();
  end

endmodule

// File: dv/gshare_predictor_with_btb_tb.sv
// ----------------------------------------------------------------------------
// gshare_predictor_with_btb_tb
// Stimulus and verdict for the gshare predictor with a target buffer.
// ----------------------------------------------------------------------------
// A directed opening covers the empty history, both misprediction cases,
// repeated and new taken branches, eviction from a full target buffer and
// counter saturation. Random predict and resolve items follow, mostly as
// predict-then-resolve pairs on a small pool of addresses so that the buffer
// hits and evicts often. Start is dropped at random, with one long stretch
// fed without gaps. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gshare_predictor_with_btb_tb;
  import gshbtb_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_kind;
  logic [ADDR_BITS-1:0]  in_branch_pc;
  logic                  in_taken;
  logic [CTR_BITS-1:0]   in_predicted_counter;
  logic [ADDR_BITS-1:0]  in_branch_target;
  logic                  out_valid;
  logic [CTR_BITS-1:0]   out_counter_value;
  logic                  out_predict_taken;
  logic                  out_btb_hit;
  logic [ADDR_BITS-1:0]  out_btb_target;
  logic                  out_mispredicted;
  logic [TOTAL_BITS-1:0] out_mispredict_total;
  int                    fail_count;
  int                    pending_count;
  int                    stall_cycles;
  bit                    gaps_on;
  logic [ADDR_BITS-1:0]  pc_pool [8];

  gshare_predictor_with_btb uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_branch_pc         (in_branch_pc),
    .in_taken             (in_taken),
    .in_predicted_counter (in_predicted_counter),
    .in_branch_target     (in_branch_target),
    .out_valid            (out_valid),
    .out_counter_value    (out_counter_value),
    .out_predict_taken    (out_predict_taken),
    .out_btb_hit          (out_btb_hit),
    .out_btb_target       (out_btb_target),
    .out_mispredicted     (out_mispredicted),
    .out_mispredict_total (out_mispredict_total)
  );

  gshare_predictor_with_btb_checker u_branch_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_kind              (in_kind),
    .in_branch_pc         (in_branch_pc),
    .in_taken             (in_taken),
    .in_predicted_counter (in_predicted_counter),
    .in_branch_target     (in_branch_target),
    .out_valid            (out_valid),
    .out_counter_value    (out_counter_value),
    .out_predict_taken    (out_predict_taken),
    .out_btb_hit          (out_btb_hit),
    .out_btb_target       (out_btb_target),
    .out_mispredicted     (out_mispredicted),
    .out_mispredict_total (out_mispredict_total),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("gshare_predictor_with_btb_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Presents one item and returns at the edge where its transfer happens.
  task automatic send_item(input kind_t kind, input logic [ADDR_BITS-1:0] pc,
                           input logic tk, input logic [CTR_BITS-1:0] pred,
                           input logic [ADDR_BITS-1:0] tgt);
    while (gaps_on && $urandom_range(99) < 27) begin
      start                <= 1'b0;
      in_kind              <= 1'($urandom);
      in_branch_pc         <= 16'($urandom);
      in_taken             <= 1'($urandom);
      in_predicted_counter <= 2'($urandom);
      in_branch_target     <= 16'($urandom);
      @(posedge clk);
    end
    start                <= 1'b1;
    in_kind              <= kind;
    in_branch_pc         <= pc;
    in_taken             <= tk;
    in_predicted_counter <= pred;
    in_branch_target     <= tgt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int                   n;
    logic [ADDR_BITS-1:0] pc;
    logic                 tk;
    start                <= 1'b0;
    rst_n                <= 1'b0;
    in_kind              <= KIND_PREDICT;
    in_branch_pc         <= '0;
    in_taken             <= 1'b0;
    in_predicted_counter <= '0;
    in_branch_target     <= '0;
    gaps_on = 1'b1;
    for (int k = 0; k < 8; k++) pc_pool[k] = 16'($urandom);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty history, then the first taken resolve and a repeat of it.
    send_item(KIND_PREDICT, 16'h0000, 1'b0, 2'd0, 16'h0000);
    send_item(KIND_PREDICT, 16'hFFFF, 1'b1, 2'd3, 16'hFFFF);
    send_item(KIND_RESOLVE, 16'h1234, 1'b1, 2'd0, 16'hFFFF);
    send_item(KIND_PREDICT, 16'h1234, 1'b0, 2'd0, 16'h0000);
    send_item(KIND_RESOLVE, 16'h1234, 1'b1, 2'd3, 16'h0000);
    send_item(KIND_PREDICT, 16'h1234, 1'b0, 2'd0, 16'h0000);
    send_item(KIND_RESOLVE, 16'hFFFF, 1'b0, 2'd2, 16'hAAAA);
    send_item(KIND_RESOLVE, 16'hFFFF, 1'b0, 2'd0, 16'h5555);
    send_item(KIND_PREDICT, 16'hFFFF, 1'b0, 2'd0, 16'h0000);
    // Fill the target buffer and push the oldest entry out.
    send_item(KIND_RESOLVE, 16'h0001, 1'b1, 2'd2, 16'h8000);
    send_item(KIND_RESOLVE, 16'h8002, 1'b1, 2'd1, 16'h0001);
    send_item(KIND_RESOLVE, 16'h4003, 1'b1, 2'd3, 16'h7FFF);
    send_item(KIND_RESOLVE, 16'h0000, 1'b1, 2'd2, 16'hFFFF);
    send_item(KIND_PREDICT, 16'h1234, 1'b0, 2'd0, 16'h0000);
    send_item(KIND_PREDICT, 16'h0000, 1'b0, 2'd0, 16'h0000);
    send_item(KIND_PREDICT, 16'h0001, 1'b0, 2'd0, 16'h0000);
    // Drive one counter to the top and another one down to the bottom.
    repeat (5) send_item(KIND_RESOLVE, 16'h5555, 1'b1, 2'd1, 16'h1111);
    send_item(KIND_PREDICT, 16'h5555, 1'b0, 2'd0, 16'h0000);
    repeat (6) send_item(KIND_RESOLVE, 16'h5550, 1'b0, 2'd3, 16'h2222);
    send_item(KIND_PREDICT, 16'h5550, 1'b0, 2'd0, 16'h0000);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      gaps_on = !(n >= 700 && n < 1100);
      pc = ($urandom_range(99) < 70) ? pc_pool[$urandom_range(7)] : 16'($urandom);
      tk = 1'($urandom);
      if ($urandom_range(99) < 60) begin
        send_item(KIND_PREDICT, pc, 1'($urandom), 2'($urandom), 16'($urandom));
        send_item(KIND_RESOLVE, pc, tk, 2'($urandom), 16'($urandom));
        n += 2;
      end else begin
        send_item(kind_t'($urandom_range(1)), pc, tk, 2'($urandom), 16'($urandom));
        n += 1;
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("gshare_predictor_with_btb_tb: PASS");
    end else begin
      $display("gshare_predictor_with_btb_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gshbtb_pkg.sv
hw/rtl/gshbtb_cell.sv
hw/rtl/gshbtb_pht.sv
hw/rtl/gshare_predictor_with_btb.sv
dv/gshare_predictor_with_btb_checker.sv
dv/gshare_predictor_with_btb_tb.sv
